[rtl/r2p_pkg.sv]
// ----------------------------------------------------------------------------
// r2p_pkg
// Shared constants, cell payload type and arctangent table for the
// rectangular to polar converter.
// ----------------------------------------------------------------------------
package r2p_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int ITERATIONS   = 16;

    localparam int STAGES = (ITERATIONS > 32) ? 32 : ITERATIONS;
    localparam int NCELL  = (STAGES > SAMPLE_WIDTH) ? STAGES : SAMPLE_WIDTH;
    localparam int IDX_W  = $clog2(NCELL);

    localparam int DW     = 64;
    localparam int GUARD  = 60 - SAMPLE_WIDTH;
    localparam int SQW    = 2 * SAMPLE_WIDTH;
    localparam int ACC_W  = 32;

    localparam logic [ACC_W-1:0] ACC_PI = 32'h8000_0000;
    localparam logic [ACC_W-1:0] PH_RND = 32'((64'd1 << (32 - SAMPLE_WIDTH)) >> 1);

    typedef struct packed {
        logic                          vld;
        logic                          zero;
        logic signed [DW-1:0]          x;
        logic signed [DW-1:0]          y;
        logic [ACC_W-1:0]              acc;
        logic [SQW-1:0]                rem;
        logic [SAMPLE_WIDTH-1:0]       root;
    } t_cell;

    function automatic logic [ACC_W-1:0] atan_unit(input logic [4:0] idx);
        logic [ACC_W-1:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10680350;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/r2p_in_if.sv]
// ----------------------------------------------------------------------------
// r2p_in_if
// Complex sample channel: valid/ready handshake with real and imaginary parts.
// ----------------------------------------------------------------------------
interface r2p_in_if;
    logic                                         valid;
    logic                                         ready;
    logic signed [r2p_pkg::SAMPLE_WIDTH-1:0]      real_part;
    logic signed [r2p_pkg::SAMPLE_WIDTH-1:0]      imag_part;

    modport source (output valid, output real_part, output imag_part, input ready);
    modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

[rtl/r2p_out_if.sv]
// ----------------------------------------------------------------------------
// r2p_out_if
// Polar result channel: valid/ready handshake with magnitude and phase.
// ----------------------------------------------------------------------------
interface r2p_out_if;
    logic                                         valid;
    logic                                         ready;
    logic        [r2p_pkg::SAMPLE_WIDTH-1:0]      magnitude;
    logic signed [r2p_pkg::SAMPLE_WIDTH-1:0]      phase_angle;

    modport source (output valid, output magnitude, output phase_angle, input ready);
    modport sink   (input valid, input magnitude, input phase_angle, output ready);
endinterface

[rtl/r2p_front.sv]
// ----------------------------------------------------------------------------
// r2p_front
// Input stage: squares for the root, guard scaling and half-plane fold for
// the vectoring chain.
// ----------------------------------------------------------------------------
module r2p_front (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_valid,
    input  logic signed [r2p_pkg::SAMPLE_WIDTH-1:0] i_real,
    input  logic signed [r2p_pkg::SAMPLE_WIDTH-1:0] i_imag,
    output r2p_pkg::t_cell                          o_stage
);

    r2p_pkg::t_cell r_stage;
    r2p_pkg::t_cell n_stage;

    logic signed [r2p_pkg::DW-1:0]  re_s;
    logic signed [r2p_pkg::DW-1:0]  im_s;
    logic signed [r2p_pkg::SQW-1:0] re_sq;
    logic signed [r2p_pkg::SQW-1:0] im_sq;

    always_comb begin
        re_sq = r2p_pkg::SQW'(i_real) * r2p_pkg::SQW'(i_real);
        im_sq = r2p_pkg::SQW'(i_imag) * r2p_pkg::SQW'(i_imag);
        re_s  = r2p_pkg::DW'(i_real) <<< r2p_pkg::GUARD;
        im_s  = r2p_pkg::DW'(i_imag) <<< r2p_pkg::GUARD;

        n_stage.vld  = i_valid;
        n_stage.zero = (i_real == '0) && (i_imag == '0);
        n_stage.rem  = r2p_pkg::SQW'(re_sq) + r2p_pkg::SQW'(im_sq);
        n_stage.root = '0;
        if (i_real < 0) begin
            n_stage.x   = -re_s;
            n_stage.y   = -im_s;
            n_stage.acc = r2p_pkg::ACC_PI;
        end else begin
            n_stage.x   = re_s;
            n_stage.y   = im_s;
            n_stage.acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[rtl/r2p_cell.sv]
// ----------------------------------------------------------------------------
// r2p_cell
// One link of the chain: a vectoring micro-rotation and one root digit.
// ----------------------------------------------------------------------------
module r2p_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [r2p_pkg::IDX_W-1:0]         i_shift,
    input  logic [r2p_pkg::IDX_W-1:0]         i_bit,
    input  logic [r2p_pkg::ACC_W-1:0]         i_atan,
    input  logic                              i_cordic_on,
    input  logic                              i_sqrt_on,
    input  r2p_pkg::t_cell                    i_stage,
    output r2p_pkg::t_cell                    o_stage
);

    r2p_pkg::t_cell r_stage;
    r2p_pkg::t_cell n_stage;

    logic signed [r2p_pkg::DW-1:0] dx;
    logic signed [r2p_pkg::DW-1:0] dy;
    logic [r2p_pkg::SQW:0]         trial;
    logic [r2p_pkg::IDX_W:0]       bit_x2;
    logic [r2p_pkg::IDX_W:0]       bit_p1;

    always_comb begin
        n_stage = i_stage;
        dx      = i_stage.y >>> i_shift;
        dy      = i_stage.x >>> i_shift;
        bit_p1  = (r2p_pkg::IDX_W+1)'(i_bit) + 1'b1;
        bit_x2  = {i_bit, 1'b0};
        trial   = ((r2p_pkg::SQW+1)'(i_stage.root) << bit_p1)
                + ((r2p_pkg::SQW+1)'(1) << bit_x2);

        if (i_cordic_on) begin
            if (i_stage.y > 0) begin
                n_stage.x   = i_stage.x + dx;
                n_stage.y   = i_stage.y - dy;
                n_stage.acc = i_stage.acc + i_atan;
            end else begin
                n_stage.x   = i_stage.x - dx;
                n_stage.y   = i_stage.y + dy;
                n_stage.acc = i_stage.acc - i_atan;
            end
        end

        if (i_sqrt_on && ({1'b0, i_stage.rem} >= trial)) begin
            n_stage.rem  = i_stage.rem - trial[r2p_pkg::SQW-1:0];
            n_stage.root = i_stage.root
                         | (r2p_pkg::SAMPLE_WIDTH'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[rtl/r2p_out.sv]
// ----------------------------------------------------------------------------
// r2p_out
// Output register: root rounding, phase rounding and zero handling.
// ----------------------------------------------------------------------------
module r2p_out (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  r2p_pkg::t_cell                          i_stage,
    output logic                                    o_valid,
    output logic        [r2p_pkg::SAMPLE_WIDTH-1:0] o_magnitude,
    output logic signed [r2p_pkg::SAMPLE_WIDTH-1:0] o_phase
);

    logic                                    r_valid;
    logic        [r2p_pkg::SAMPLE_WIDTH-1:0] r_mag;
    logic signed [r2p_pkg::SAMPLE_WIDTH-1:0] r_phase;
    logic        [r2p_pkg::SAMPLE_WIDTH-1:0] n_mag;
    logic signed [r2p_pkg::SAMPLE_WIDTH-1:0] n_phase;
    logic        [r2p_pkg::ACC_W-1:0]        ph_sum;

    always_comb begin
        ph_sum = i_stage.acc + r2p_pkg::PH_RND;
        n_mag  = i_stage.root
               + r2p_pkg::SAMPLE_WIDTH'(i_stage.rem > r2p_pkg::SQW'(i_stage.root));
        if (i_stage.zero) begin
            n_phase = '0;
        end else begin
            n_phase = ph_sum[r2p_pkg::ACC_W-1 -: r2p_pkg::SAMPLE_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.vld;
            r_mag   <= n_mag;
            r_phase <= n_phase;
        end
    end

    assign o_valid     = r_valid;
    assign o_magnitude = r_mag;
    assign o_phase     = r_phase;

endmodule

[rtl/rect_to_polar_converter.sv]
// ----------------------------------------------------------------------------
// rect_to_polar_converter
// Magnitude and phase of one complex sample per item.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample carries real_part and imag_part (signed Q1.15); o_polar returns
//   magnitude (unsigned, same scale, rounded to nearest) and phase_angle
//   (signed, pi = 32768; +pi reads as -32768, a zero sample gives 0).
//   Both channels use valid/ready; an item moves when both are high.
//   Throughput: one item per cycle while o_polar is not stalled. Each item
//   passes in turn through the input stage, the chain of NCELL cells, each
//   doing one vectoring micro-rotation and one square-root digit, and the
//   output register.
//   The whole pipe advances together: when o_polar is stalled with a result
//   held, i_sample.ready drops and every stage holds. Bubbles travel through,
//   so input ready stays high while the output register is empty.
//   Reset (synchronous, active low) clears all valid flags; no results are
//   pending afterwards and the block takes items in the next cycle.
// ----------------------------------------------------------------------------
module rect_to_polar_converter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    r2p_in_if.sink         i_sample,
    r2p_out_if.source      o_polar
);

    logic           adv;
    r2p_pkg::t_cell chain [r2p_pkg::NCELL+1];

    assign adv            = !o_polar.valid || o_polar.ready;
    assign i_sample.ready = adv;

    r2p_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_sample.valid),
        .i_real  (i_sample.real_part),
        .i_imag  (i_sample.imag_part),
        .o_stage (chain[0])
    );

    for (genvar k = 0; k < r2p_pkg::NCELL; k++) begin : g_cell
        r2p_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (adv),
            .i_shift     (r2p_pkg::IDX_W'(k)),
            .i_bit       (r2p_pkg::IDX_W'((k < r2p_pkg::SAMPLE_WIDTH)
                              ? (r2p_pkg::SAMPLE_WIDTH - 1 - k) : 0)),
            .i_atan      (r2p_pkg::atan_unit(5'(k))),
            .i_cordic_on (k < r2p_pkg::STAGES),
            .i_sqrt_on   (k < r2p_pkg::SAMPLE_WIDTH),
            .i_stage     (chain[k]),
            .o_stage     (chain[k+1])
        );
    end

    r2p_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_stage     (chain[r2p_pkg::NCELL]),
        .o_valid     (o_polar.valid),
        .o_magnitude (o_polar.magnitude),
        .o_phase     (o_polar.phase_angle)
    );

endmodule

[rtl/r2p_checker.sv]
// ----------------------------------------------------------------------------
// r2p_checker
// Port-level checks for the rectangular to polar converter.
// ----------------------------------------------------------------------------
module r2p_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [r2p_pkg::SAMPLE_WIDTH-1:0] i_mag,
    input logic [r2p_pkg::SAMPLE_WIDTH-1:0] i_phase
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not track output register");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_mag) && $stable(i_phase))
        else $error("stalled result changed");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !(i_out_valid && !i_out_ready))
        else $error("item taken while result stalled");

endmodule

bind rect_to_polar_converter r2p_checker u_r2p_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_polar.valid),
    .i_out_ready (o_polar.ready),
    .i_mag       (o_polar.magnitude),
    .i_phase     (o_polar.phase_angle)
);

[test/rect_to_polar_converter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_to_polar_converter_tb
// Checks magnitude and phase of complex samples against a bit-exact model.
// A short table of corner samples runs first, followed by about two thousand
// random samples. Both channels idle in random short bursts. The model does
// a CORDIC vectoring pass for the phase and an exact rounded square root for
// the magnitude. Every result is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module rect_to_polar_converter_tb;

    localparam int SW           = r2p_pkg::SAMPLE_WIDTH;
    localparam int ROTATIONS    = (r2p_pkg::ITERATIONS > 32) ? 32 : r2p_pkg::ITERATIONS;
    localparam int LATENCY      = r2p_pkg::NCELL + 2;
    localparam int RANDOM_ITEMS = 2000;
    localparam int QUIET_TAIL   = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [31:0]          HALF_TURN = 32'h8000_0000;

    localparam logic [0:31][31:0] ARCTAN_STEP = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680350,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic [SW-1:0]        magnitude;
        logic signed [SW-1:0] phase_angle;
    } t_polar;

    typedef struct packed {
        logic                 pinned;
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        logic [SW-1:0]        magnitude;
        logic signed [SW-1:0] phase_angle;
    } t_corner_row;

    localparam int CORNER_ROWS = 22;

    // pinned rows carry their own expected result
    localparam t_corner_row [0:CORNER_ROWS-1] CORNER_SAMPLES = '{
        '{1'b1, SW'(0),      SW'(0),     '0, '0},
        '{1'b0, SMAX,        SW'(0),     '0, '0},
        '{1'b0, SMIN,        SW'(0),     '0, '0},
        '{1'b0, SW'(0),      SMAX,       '0, '0},
        '{1'b0, SW'(0),      SMIN,       '0, '0},
        '{1'b0, SMAX,        SMAX,       '0, '0},
        '{1'b0, SMIN,        SMIN,       '0, '0},
        '{1'b0, SMAX,        SMIN,       '0, '0},
        '{1'b0, SMIN,        SMAX,       '0, '0},
        '{1'b0, SW'(-1),     SW'(0),     '0, '0},
        '{1'b0, SW'(-1),     SW'(1),     '0, '0},
        '{1'b0, SW'(-1),     SW'(-1),    '0, '0},
        '{1'b0, SW'(1),      SW'(0),     '0, '0},
        '{1'b0, SW'(0),      SW'(1),     '0, '0},
        '{1'b0, SW'(1),      SW'(1),     '0, '0},
        '{1'b0, SMIN,        SW'(1),     '0, '0},
        '{1'b0, SMIN,        SW'(-1),    '0, '0},
        '{1'b0, SW'(-100),   SW'(0),     '0, '0},
        '{1'b0, SW'(-2),     SW'(-1),    '0, '0},
        '{1'b0, SW'(12345),  SW'(-6789), '0, '0},
        '{1'b0, SW'(-20000), SW'(15000), '0, '0},
        '{1'b1, SW'(0),      SW'(0),     '0, '0}
    };

    logic i_clk = 1'b0;
    logic rst_n;

    r2p_in_if  sample_if ();
    r2p_out_if polar_if ();

    rect_to_polar_converter dut (
        .i_clk    (i_clk),
        .i_rst_n  (rst_n),
        .i_sample (sample_if),
        .o_polar  (polar_if)
    );

    always #6 i_clk = ~i_clk;

    t_polar pending_results[$];
    int     error_count = 0;
    int     cycle_count = 0;
    int     stall_left  = 0;
    bit     src_gaps    = 1'b0;
    bit     sink_stalls = 1'b0;

    function automatic t_polar polar_of(input logic signed [SW-1:0] re,
                                        input logic signed [SW-1:0] im);
        t_polar      res;
        longint      sq;
        longint      root;
        longint      trial;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        logic [31:0] acc;
        logic [31:0] rounded;

        sq   = longint'(re) * longint'(re) + longint'(im) * longint'(im);
        root = 0;
        for (int b = SW - 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sq) begin
                root = trial;
            end
        end
        if (sq - root * root > root) begin
            root = root + 1;
        end
        res.magnitude = root[SW-1:0];

        if (re == 0 && im == 0) begin
            res.phase_angle = '0;
            return res;
        end

        x   = longint'(re) * (longint'(1) << (60 - SW));
        y   = longint'(im) * (longint'(1) << (60 - SW));
        acc = '0;
        if (x < 0) begin
            x   = -x;
            y   = -y;
            acc = HALF_TURN;
        end
        for (int i = 0; i < ROTATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x   = x + dx;
                y   = y - dy;
                acc = acc + ARCTAN_STEP[i];
            end else begin
                x   = x - dx;
                y   = y + dy;
                acc = acc - ARCTAN_STEP[i];
            end
        end
        rounded = (acc + (32'd1 << (31 - SW))) >> (32 - SW);
        res.phase_angle = rounded[SW-1:0];
        return res;
    endfunction

    function automatic logic signed [SW-1:0] random_part(input int kind);
        logic signed [SW-1:0] v;
        v = SW'($urandom);
        case (kind)
            0: v = SW'(int'($urandom_range(0, 8)) - 4);
            1: begin
                case ($urandom_range(0, 5))
                    0: v = SMIN;
                    1: v = SMIN + SW'(1);
                    2: v = '1;
                    3: v = '0;
                    4: v = SW'(1);
                    default: v = SMAX;
                endcase
            end
            2: v = v | SMIN;
            default: ;
        endcase
        return v;
    endfunction

    task automatic flag_error(input string what, input int want, input int got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("mismatch %s: expected %0d, got %0d (cycle %0d)",
                     what, want, got, cycle_count);
        end
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic drive_sample(input logic signed [SW-1:0] re,
                                input logic signed [SW-1:0] im,
                                input t_polar               want);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        sample_if.valid     <= 1'b1;
        sample_if.real_part <= re;
        sample_if.imag_part <= im;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
        pending_results.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic wait_drained;
        sample_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            polar_if.ready <= 1'b0;
            stall_left--;
        end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
            polar_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            polar_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_polar want;
        if (rst_n && polar_if.valid && polar_if.ready) begin
            if (pending_results.size() == 0) begin
                flag_error("unexpected item, magnitude", 0, int'(polar_if.magnitude));
            end else begin
                want = pending_results.pop_front();
                if (polar_if.magnitude !== want.magnitude) begin
                    flag_error("magnitude", int'(want.magnitude),
                               int'(polar_if.magnitude));
                end
                if (polar_if.phase_angle !== want.phase_angle) begin
                    flag_error("phase_angle", int'(want.phase_angle),
                               int'(polar_if.phase_angle));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_corner_row          row;
        t_polar               want;
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        int                   kind;

        rst_n               = 1'b0;
        sample_if.valid     = 1'b0;
        sample_if.real_part = '0;
        sample_if.imag_part = '0;
        repeat (4) @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        for (int n = 0; n < CORNER_ROWS; n++) begin
            row = CORNER_SAMPLES[n];
            if (row.pinned) begin
                want.magnitude   = row.magnitude;
                want.phase_angle = row.phase_angle;
            end else begin
                want = polar_of(row.re, row.im);
            end
            drive_sample(row.re, row.im, want);
        end
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
                src_gaps    = 1'b0;
                sink_stalls = 1'b0;
            end else if (n % 150 == 0) begin
                src_gaps    = $urandom_range(0, 2) != 0;
                sink_stalls = $urandom_range(0, 2) != 0;
            end
            if (n == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    re = random_part(0);
                    im = random_part(0);
                end
                1: begin
                    re = random_part(1);
                    im = random_part(1);
                end
                2: begin
                    re = random_part(1);
                    im = random_part(3);
                end
                3: begin
                    re = random_part(3);
                    im = random_part(1);
                end
                4: begin
                    // negative real axis and its close neighbors
                    re = random_part(2);
                    im = random_part(0);
                end
                default: begin
                    re = random_part(3);
                    im = random_part(3);
                end
            endcase
            drive_sample(re, im, polar_of(re, im));
        end

        wait_drained();
        repeat (LATENCY + 4) @(negedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
